### src/tpgcm_pkg.sv
// ----------------------------------------------------------------------------
// tpgcm_pkg
// Shared widths, types and constants of the three-point gradient color map.
// ----------------------------------------------------------------------------
package tpgcm_pkg;

   localparam int SAMPLE_WIDTH  = 16;
   localparam int FRACTION_BITS = 16;
   localparam int DIFF_WIDTH    = SAMPLE_WIDTH + 1;
   localparam int CHAN_WIDTH    = FRACTION_BITS + 1;
   localparam int DIV_STAGES    = FRACTION_BITS;
   localparam int COLOR_WIDTH   = 16;
   localparam int ADDR_WIDTH    = 4;
   localparam int DATA_WIDTH    = 32;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [DIFF_WIDTH-1:0]          diff_type;
   typedef logic [FRACTION_BITS-1:0]       fraction_type;
   typedef logic [CHAN_WIDTH-1:0]          chan_type;
   typedef logic [COLOR_WIDTH-1:0]         color_type;
   typedef logic [1:0]                     reg_index_type;

   localparam reg_index_type REG_MIN    = 2'd0;
   localparam reg_index_type REG_TARGET = 2'd1;
   localparam reg_index_type REG_MAX    = 2'd2;

   localparam sample_type MIN_RESET    = sample_type'(960);
   localparam sample_type TARGET_RESET = sample_type'(1440);
   localparam sample_type MAX_RESET    = sample_type'(1760);

   localparam color_type COLOR_RED   = 16'hF800;
   localparam color_type COLOR_BLUE  = 16'h001F;
   localparam color_type COLOR_WHITE = 16'hFFFF;

   localparam fraction_type FRACTION_HALF = fraction_type'(1) << (FRACTION_BITS - 1);
   localparam chan_type     CHAN_ONE      = chan_type'(1) << FRACTION_BITS;

   // Side information that travels with a sample through the divider
   typedef struct packed {
      logic      fixed;
      color_type fixed_color;
      logic      below;
   } tag_type;

endpackage

### src/tpgcm_if.sv
// ----------------------------------------------------------------------------
// tpgcm channel interfaces
// Valid/ready channels for samples in and colors out.
// ----------------------------------------------------------------------------
interface tpgcm_req_if;
   logic                  valid;
   logic                  ready;
   tpgcm_pkg::sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface tpgcm_rsp_if;
   logic                 valid;
   logic                 ready;
   tpgcm_pkg::color_type color;

   modport source (output valid, output color, input ready);
   modport sink   (input valid, input color, output ready);
endinterface

### src/tpgcm_divider.sv
// ----------------------------------------------------------------------------
// tpgcm_divider
// Pipelined restoring divider: one quotient bit per stage, remainder < divisor.
// ----------------------------------------------------------------------------
module tpgcm_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  tpgcm_pkg::tag_type     in_tag,
   input  tpgcm_pkg::diff_type    in_rem,
   input  tpgcm_pkg::diff_type    in_den,
   output logic                   out_valid,
   output tpgcm_pkg::tag_type     out_tag,
   output tpgcm_pkg::fraction_type out_quot
);

   logic [tpgcm_pkg::DIV_STAGES-1:0] valid_ff;
   tpgcm_pkg::tag_type      tag_ff  [tpgcm_pkg::DIV_STAGES];
   tpgcm_pkg::diff_type     rem_ff  [tpgcm_pkg::DIV_STAGES];
   tpgcm_pkg::diff_type     den_ff  [tpgcm_pkg::DIV_STAGES];
   tpgcm_pkg::fraction_type quot_ff [tpgcm_pkg::DIV_STAGES];

   for (genvar k = 0; k < tpgcm_pkg::DIV_STAGES; k++) begin : g_stage
      logic                    prev_valid;
      tpgcm_pkg::tag_type      prev_tag;
      tpgcm_pkg::diff_type     prev_rem;
      tpgcm_pkg::diff_type     prev_den;
      tpgcm_pkg::fraction_type prev_quot;
      logic [tpgcm_pkg::DIFF_WIDTH:0] shifted;
      logic [tpgcm_pkg::DIFF_WIDTH:0] trial;
      logic                    take;
      tpgcm_pkg::diff_type     rem_in;
      tpgcm_pkg::fraction_type quot_in;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_tag   = in_tag;
         assign prev_rem   = in_rem;
         assign prev_den   = in_den;
         assign prev_quot  = '0;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_tag   = tag_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_den   = den_ff[k-1];
         assign prev_quot  = quot_ff[k-1];
      end

      // no borrow out of the trial subtract means the bit is one
      assign shifted = {prev_rem, 1'b0};
      assign trial   = shifted - {1'b0, prev_den};
      assign take    = !trial[tpgcm_pkg::DIFF_WIDTH];
      assign rem_in  = take ? trial[tpgcm_pkg::DIFF_WIDTH-1:0]
                            : shifted[tpgcm_pkg::DIFF_WIDTH-1:0];
      assign quot_in = {prev_quot[tpgcm_pkg::FRACTION_BITS-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            tag_ff[k]  <= prev_tag;
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= prev_den;
            quot_ff[k] <= quot_in;
         end
      end
   end

   assign out_valid = valid_ff[tpgcm_pkg::DIV_STAGES-1];
   assign out_tag   = tag_ff[tpgcm_pkg::DIV_STAGES-1];
   assign out_quot  = quot_ff[tpgcm_pkg::DIV_STAGES-1];

endmodule

### src/three_point_gradient_color_map_unit.sv
// ----------------------------------------------------------------------------
// three_point_gradient_color_map_unit
// Maps a signed Q12.4 sample to an RGB565 blue-green-red gradient color.
// ----------------------------------------------------------------------------
// Accepts one sample per clock while rsp_chan is not stalled and passes it
// through one input register, a 16-stage divider pipeline that resolves one
// fraction bit per stage, and one output register. The whole pipeline holds
// while a finished color waits on rsp_chan. The three levels are written over
// the APB port at byte addresses 0, 4 and 8 (min, target, max) and should only
// change while no sample is in flight.
module three_point_gradient_color_map_unit (
   input  logic                             clock,
   input  logic                             reset,
   tpgcm_req_if.sink                        req_chan,
   tpgcm_rsp_if.source                      rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tpgcm_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [tpgcm_pkg::DATA_WIDTH-1:0] pwdata,
   output logic [tpgcm_pkg::DATA_WIDTH-1:0] prdata,
   output logic                             pready
);

   tpgcm_pkg::sample_type    min_ff, target_ff, max_ff;
   tpgcm_pkg::sample_type    min_in, target_in, max_in;
   tpgcm_pkg::reg_index_type reg_index;
   logic                     cfg_write;

   logic                     advance;

   tpgcm_pkg::sample_type    sample;
   logic                     at_max, at_min, bad_levels, below;
   tpgcm_pkg::diff_type      num_in, den_in;
   tpgcm_pkg::tag_type       tag_in;

   logic                     s0_valid_ff;
   tpgcm_pkg::tag_type       s0_tag_ff;
   tpgcm_pkg::diff_type      s0_rem_ff, s0_den_ff;

   logic                     div_valid;
   tpgcm_pkg::tag_type       div_tag;
   tpgcm_pkg::fraction_type  div_quot;

   tpgcm_pkg::chan_type      twice, falling;
   tpgcm_pkg::chan_type      red_c, green_c, blue_c;
   tpgcm_pkg::color_type     color_in;

   logic                     rsp_valid_ff;
   tpgcm_pkg::color_type     rsp_color_ff;

   function automatic logic [4:0] scale31(input tpgcm_pkg::chan_type c);
      logic [tpgcm_pkg::CHAN_WIDTH+4:0] p;
      p = (tpgcm_pkg::CHAN_WIDTH+5)'(c) * (tpgcm_pkg::CHAN_WIDTH+5)'(31);
      return p[tpgcm_pkg::FRACTION_BITS+4:tpgcm_pkg::FRACTION_BITS];
   endfunction

   function automatic logic [5:0] scale63(input tpgcm_pkg::chan_type c);
      logic [tpgcm_pkg::CHAN_WIDTH+5:0] p;
      p = (tpgcm_pkg::CHAN_WIDTH+6)'(c) * (tpgcm_pkg::CHAN_WIDTH+6)'(63);
      return p[tpgcm_pkg::FRACTION_BITS+5:tpgcm_pkg::FRACTION_BITS];
   endfunction

   // ---------------- configuration registers ----------------
   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      min_in    = min_ff;
      target_in = target_ff;
      max_in    = max_ff;
      if (cfg_write) begin
         unique case (reg_index)
            tpgcm_pkg::REG_MIN:    min_in    = pwdata[tpgcm_pkg::SAMPLE_WIDTH-1:0];
            tpgcm_pkg::REG_TARGET: target_in = pwdata[tpgcm_pkg::SAMPLE_WIDTH-1:0];
            tpgcm_pkg::REG_MAX:    max_in    = pwdata[tpgcm_pkg::SAMPLE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff    <= tpgcm_pkg::MIN_RESET;
         target_ff <= tpgcm_pkg::TARGET_RESET;
         max_ff    <= tpgcm_pkg::MAX_RESET;
      end else begin
         min_ff    <= min_in;
         target_ff <= target_in;
         max_ff    <= max_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         tpgcm_pkg::REG_MIN:
            prdata = (tpgcm_pkg::DATA_WIDTH)'(unsigned'(min_ff));
         tpgcm_pkg::REG_TARGET:
            prdata = (tpgcm_pkg::DATA_WIDTH)'(unsigned'(target_ff));
         tpgcm_pkg::REG_MAX:
            prdata = (tpgcm_pkg::DATA_WIDTH)'(unsigned'(max_ff));
         default:
            prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   // hold every stage while a finished color is not taken
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // ---------------- classify and set up the division ----------------
   assign sample     = req_chan.sample;
   assign at_max     = sample >= max_ff;
   assign at_min     = sample <= min_ff;
   assign bad_levels = (target_ff <= min_ff) || (max_ff <= target_ff);
   assign below      = sample < target_ff;

   always_comb begin
      if (below) begin
         num_in = tpgcm_pkg::diff_type'((tpgcm_pkg::DIFF_WIDTH)'(sample)
                                      - (tpgcm_pkg::DIFF_WIDTH)'(min_ff));
         den_in = tpgcm_pkg::diff_type'((tpgcm_pkg::DIFF_WIDTH)'(target_ff)
                                      - (tpgcm_pkg::DIFF_WIDTH)'(min_ff));
      end else begin
         num_in = tpgcm_pkg::diff_type'((tpgcm_pkg::DIFF_WIDTH)'(sample)
                                      - (tpgcm_pkg::DIFF_WIDTH)'(target_ff));
         den_in = tpgcm_pkg::diff_type'((tpgcm_pkg::DIFF_WIDTH)'(max_ff)
                                      - (tpgcm_pkg::DIFF_WIDTH)'(target_ff));
      end
   end

   always_comb begin
      tag_in.fixed = at_max || at_min || bad_levels;
      tag_in.below = below;
      priority if (at_max) begin
         tag_in.fixed_color = tpgcm_pkg::COLOR_RED;
      end else if (at_min) begin
         tag_in.fixed_color = tpgcm_pkg::COLOR_BLUE;
      end else begin
         tag_in.fixed_color = tpgcm_pkg::COLOR_WHITE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_tag_ff <= tag_in;
         s0_rem_ff <= num_in;
         s0_den_ff <= den_in;
      end
   end

   tpgcm_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s0_valid_ff),
      .in_tag    (s0_tag_ff),
      .in_rem    (s0_rem_ff),
      .in_den    (s0_den_ff),
      .out_valid (div_valid),
      .out_tag   (div_tag),
      .out_quot  (div_quot)
   );

   // ---------------- gradient and channel scaling ----------------
   assign twice   = {div_quot, 1'b0};
   assign falling = tpgcm_pkg::chan_type'(0) - twice;

   always_comb begin
      red_c   = '0;
      green_c = '0;
      blue_c  = '0;
      if (div_tag.below) begin
         if (div_quot <= tpgcm_pkg::FRACTION_HALF) begin
            blue_c  = tpgcm_pkg::CHAN_ONE;
            green_c = twice;
         end else begin
            green_c = tpgcm_pkg::CHAN_ONE;
            blue_c  = falling;
         end
      end else begin
         if (div_quot <= tpgcm_pkg::FRACTION_HALF) begin
            green_c = tpgcm_pkg::CHAN_ONE;
            red_c   = twice;
         end else begin
            red_c   = tpgcm_pkg::CHAN_ONE;
            green_c = falling;
         end
      end
   end

   assign color_in = div_tag.fixed ? div_tag.fixed_color
                                   : {scale31(red_c), scale63(green_c), scale31(blue_c)};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_color_ff <= color_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.color = rsp_color_ff;

endmodule
